/* rtl/eqfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqfs_pkg
// Shared types and constants for the event queue with front slot.
// ----------------------------------------------------------------------------
package eqfs_pkg;

  // Built ring depth and handle width
  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;

  // Derived widths
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int OCC_W  = 5;
  localparam int HW_W   = 5;

  // Port widths
  localparam int ACT_W      = 3;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 32;
  localparam int M_TUSER_W  = 2;
  localparam int M_PAD_W    = M_TDATA_W - HANDLE_BITS - OCC_W - HW_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Queue actions
  typedef enum logic [ACT_W-1:0] {
    ACT_PUT_FIFO = 3'd0,
    ACT_PUT_LIFO = 3'd1,
    ACT_GET      = 3'd2,
    ACT_PEEK     = 3'd3,
    ACT_FLUSH    = 3'd4
  } action_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_t;

endpackage

`default_nettype wire

/* rtl/event_queue_with_front_slot_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_queue_with_front_slot_unit
// Event-handle queue: a front holding slot plus a ring held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_tuser carries the action (put fifo, put lifo, get, peek,
//   flush), s_tdata the event handle for puts. Master stream returns one
//   transaction per accepted item: m_tuser flags ok/event_valid, tdata the
//   front handle, occupancy and ring high-water mark.
//   Every action's result is loaded into the output register on accept; a get
//   that refills the front from the ring is offered only after the fill state,
//   because the ring RAM read at the tail index returns registered data.
//   Throughput: one item per cycle while the receiver keeps up; a refilling
//   get holds the input in the fill state while the RAM read completes.
//   The result sits in an output register; a new item is taken in the same
//   cycle the previous result is taken. If the receiver stalls, tready drops
//   once a result is waiting, and the result holds steady.
//   Reset clears pointers, counts, the front slot and sets capacity to 16;
//   ring contents are left undefined and never read before being written.
//   cfg_we writes capacity; write it only while the queue is idle.
// ----------------------------------------------------------------------------
module event_queue_with_front_slot_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration: capacity
  input  wire logic                               cfg_we,
  input  wire logic [eqfs_pkg::CAP_W-1:0]         cfg_wdata,
  // Input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [eqfs_pkg::S_TDATA_W-1:0]     s_tdata,  // [15:0] event_in
  input  wire logic [eqfs_pkg::ACT_W-1:0]         s_tuser,  // [2:0] action
  // Output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [15:0] event_out, [20:16] occupancy, [25:21] high_water, [31:26] zero
  output logic      [eqfs_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic      [eqfs_pkg::M_TUSER_W-1:0]     m_tuser   // [0] ok, [1] event_valid
);

  localparam int IDX_W  = eqfs_pkg::IDX_W;
  localparam int CNT_W  = eqfs_pkg::CNT_W;
  localparam int WIDE_W = eqfs_pkg::WIDE_W;
  localparam int HB     = eqfs_pkg::HANDLE_BITS;
  localparam int OCC_W  = eqfs_pkg::OCC_W;
  localparam int HW_W   = eqfs_pkg::HW_W;

  // Control and pointer registers
  eqfs_pkg::state_t            state;
  logic [eqfs_pkg::CAP_W-1:0]  capacity;
  logic [IDX_W-1:0]            head, head_next;
  logic [IDX_W-1:0]            tail, tail_next;
  logic [CNT_W-1:0]            count, count_next;
  logic [CNT_W-1:0]            peak, peak_next;
  logic [HB-1:0]               front_ev, front_ev_next;
  logic                        front_v, front_v_next;

  // Output register
  logic                        out_valid;
  logic                        out_ok, out_evalid;
  logic [HB-1:0]               out_event;
  logic [OCC_W-1:0]            out_occ;
  logic [HW_W-1:0]             out_hw;

  // Step results
  logic                        r_ok, r_evalid, refill;
  logic [HB-1:0]               r_event;
  logic                        accept;
  eqfs_pkg::action_t           act;
  logic [CNT_W-1:0]            cap;
  logic [CNT_W-1:0]            head_p1, tail_p1;
  logic [IDX_W-1:0]            head_adv, tail_adv, tail_dec;

  // RAM port
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [HB-1:0]               ram_wdata;
  logic [HB-1:0]               ram_rdata;

  eqfs_ram #(
    .WIDTH (HB),
    .DEPTH (eqfs_pkg::DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (tail),
    .rdata (ram_rdata)
  );

  // Handshake
  assign s_tready = (state == eqfs_pkg::ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign act      = eqfs_pkg::action_t'(s_tuser);

  // Effective capacity, clamped to the built depth
  assign cap = (WIDE_W'(capacity) > WIDE_W'(eqfs_pkg::DEPTH)) ?
               CNT_W'(eqfs_pkg::DEPTH) : CNT_W'(capacity);

  // Pointer moves with wrap at capacity
  assign head_p1  = CNT_W'(head) + CNT_W'(1);
  assign tail_p1  = CNT_W'(tail) + CNT_W'(1);
  assign head_adv = (head_p1 >= cap) ? '0 : head_p1[IDX_W-1:0];
  assign tail_adv = (tail_p1 >= cap) ? '0 : tail_p1[IDX_W-1:0];
  always_comb begin
    logic [CNT_W-1:0] cap_m1;
    cap_m1   = cap - CNT_W'(1);
    tail_dec = (tail == '0) ? cap_m1[IDX_W-1:0] : tail - IDX_W'(1);
  end

  // Action decode and next state
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    peak_next     = peak;
    front_ev_next = front_ev;
    front_v_next  = front_v;
    ram_we        = 1'b0;
    ram_waddr     = head;
    ram_wdata     = s_tdata;
    r_ok          = 1'b0;
    r_evalid      = 1'b0;
    r_event       = '0;
    refill        = 1'b0;
    unique case (act) inside
      eqfs_pkg::ACT_PUT_FIFO, eqfs_pkg::ACT_PUT_LIFO: begin
        if (!front_v) begin
          front_ev_next = s_tdata;
          front_v_next  = 1'b1;
          r_ok          = 1'b1;
        end else if (count < cap) begin
          count_next = count + CNT_W'(1);
          if (count_next > peak) begin
            peak_next = count_next;
          end
          ram_we = 1'b1;
          if (act == eqfs_pkg::ACT_PUT_FIFO) begin
            ram_waddr = head;
            ram_wdata = s_tdata;
            head_next = head_adv;
          end else begin
            // push current front back in before the tail
            ram_waddr     = tail_dec;
            ram_wdata     = front_ev;
            tail_next     = tail_dec;
            front_ev_next = s_tdata;
          end
          r_ok = 1'b1;
        end
      end
      eqfs_pkg::ACT_GET: begin
        if (front_v) begin
          r_ok     = 1'b1;
          r_evalid = 1'b1;
          r_event  = front_ev;
          if (count != '0) begin
            // front refilled from ring tail in the fill state
            count_next = count - CNT_W'(1);
            tail_next  = tail_adv;
            refill     = 1'b1;
          end else begin
            front_v_next  = 1'b0;
            front_ev_next = '0;
          end
        end
      end
      eqfs_pkg::ACT_PEEK: begin
        if (front_v) begin
          r_ok     = 1'b1;
          r_evalid = 1'b1;
          r_event  = front_ev;
        end
      end
      eqfs_pkg::ACT_FLUSH: begin
        head_next     = '0;
        tail_next     = '0;
        count_next    = '0;
        front_v_next  = 1'b0;
        front_ev_next = '0;
        r_ok          = 1'b1;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ram_we = 1'b0;
    end
  end

  // State, pointer and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= eqfs_pkg::ST_IDLE;
      capacity  <= eqfs_pkg::CAP_RESET;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      peak      <= '0;
      front_ev  <= '0;
      front_v   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      unique case (state)
        eqfs_pkg::ST_IDLE: begin
          if (accept) begin
            head       <= head_next;
            tail       <= tail_next;
            count      <= count_next;
            peak       <= peak_next;
            front_ev   <= front_ev_next;
            front_v    <= front_v_next;
            out_ok     <= r_ok;
            out_evalid <= r_evalid;
            out_event  <= r_event;
            out_occ    <= OCC_W'(count_next) + OCC_W'(front_v_next);
            out_hw     <= HW_W'(peak_next);
            // a waiting result is taken in this cycle whenever an item is
            if (refill) begin
              state     <= eqfs_pkg::ST_FILL;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (m_tvalid && m_tready) begin
            out_valid <= 1'b0;
          end
        end
        eqfs_pkg::ST_FILL: begin
          front_ev  <= ram_rdata;
          out_valid <= 1'b1;
          state     <= eqfs_pkg::ST_IDLE;
        end
        default: begin
          state <= eqfs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Output stream
  assign m_tvalid = out_valid;
  assign m_tdata  = {{eqfs_pkg::M_PAD_W{1'b0}}, out_hw, out_occ, out_event};
  assign m_tuser  = {out_evalid, out_ok};

endmodule

`default_nettype wire

/* rtl/eqfs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eqfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/eqfs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqfs_checker
// Port-level checks for the event queue with front slot.
// ----------------------------------------------------------------------------
module eqfs_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [eqfs_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [eqfs_pkg::M_TUSER_W-1:0] m_tuser
);

  // Stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A returned event always means success
  a_evalid_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("event_valid without ok");

  // No event means zero handle
  a_event_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[15:0] == 16'd0)
    else $error("event_out nonzero without event");

  // Ring part of occupancy never exceeds the high-water mark
  a_occ_hw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {1'b0, m_tdata[20:16]} <= {1'b0, m_tdata[25:21]} + 6'd1)
    else $error("occupancy above high-water mark");

endmodule

bind event_queue_with_front_slot_unit eqfs_checker u_eqfs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
